[rtl/core/asbs_pkg.sv]
// ----------------------------------------------------------------------------
// asbs_pkg: shared types, constants and nibble tables
// tables and item type used by the sample byte scrambler modules
// ----------------------------------------------------------------------------
package asbs_pkg;

	localparam logic [7:0] LabelByte = 8'h40;
	localparam logic [3:0] OffsetMax = 4'd15;
	localparam logic [4:0] NibLast   = 5'd14;
	localparam logic [3:0] HiSpecial = 4'h9;
	localparam logic [4:0] RingLen   = 5'd15;

	typedef struct packed {
		logic [31:0] sample;
		logic        frame_start;
	} item_t;

	// pattern length per low nibble of the index byte
	function automatic logic [3:0] pat_len(input logic [3:0] lo);
		logic [3:0] r;
		unique case (lo)
			4'h0: r = 4'd0;
			4'h1: r = 4'd1;
			4'h2: r = 4'd3;
			4'h3: r = 4'd5;
			4'h4: r = 4'd7;
			4'h5: r = 4'd9;
			4'h6: r = 4'd11;
			4'h7: r = 4'd13;
			4'h8: r = 4'd14;
			4'h9: r = 4'd12;
			4'ha: r = 4'd10;
			4'hb: r = 4'd8;
			4'hc: r = 4'd6;
			4'hd: r = 4'd4;
			4'he: r = 4'd2;
			4'hf: r = 4'd0;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// low nibble sequence, 15 entries
	function automatic logic [3:0] lo_seq(input logic [3:0] pos);
		logic [3:0] r;
		unique case (pos)
			4'd0:  r = 4'h8;
			4'd1:  r = 4'h7;
			4'd2:  r = 4'h9;
			4'd3:  r = 4'h6;
			4'd4:  r = 4'ha;
			4'd5:  r = 4'h5;
			4'd6:  r = 4'hb;
			4'd7:  r = 4'h4;
			4'd8:  r = 4'hc;
			4'd9:  r = 4'h3;
			4'd10: r = 4'hd;
			4'd11: r = 4'h2;
			4'd12: r = 4'he;
			4'd13: r = 4'h1;
			4'd14: r = 4'hf;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	// high nibble ring, 15 entries
	function automatic logic [3:0] hi_ring(input logic [3:0] pos);
		logic [3:0] r;
		unique case (pos)
			4'd0:  r = 4'h0;
			4'd1:  r = 4'h6;
			4'd2:  r = 4'hf;
			4'd3:  r = 4'h8;
			4'd4:  r = 4'h7;
			4'd5:  r = 4'h5;
			4'd6:  r = 4'h3;
			4'd7:  r = 4'h4;
			4'd8:  r = 4'hc;
			4'd9:  r = 4'hd;
			4'd10: r = 4'he;
			4'd11: r = 4'h1;
			4'd12: r = 4'h2;
			4'd13: r = 4'hb;
			4'd14: r = 4'ha;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	// start position in the high ring per high nibble
	function automatic logic [3:0] hi_start(input logic [3:0] hi);
		logic [3:0] r;
		unique case (hi)
			4'h0: r = 4'd0;
			4'h1: r = 4'd11;
			4'h2: r = 4'd12;
			4'h3: r = 4'd6;
			4'h4: r = 4'd7;
			4'h5: r = 4'd5;
			4'h6: r = 4'd1;
			4'h7: r = 4'd4;
			4'h8: r = 4'd3;
			4'h9: r = 4'd0;
			4'ha: r = 4'd14;
			4'hb: r = 4'd13;
			4'hc: r = 4'd8;
			4'hd: r = 4'd9;
			4'he: r = 4'd10;
			4'hf: r = 4'd2;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/asbs_salt_lut.sv]
// ----------------------------------------------------------------------------
// asbs_salt_lut: next salt lookup
// forms the salt byte from the index byte and the channel offset
// ----------------------------------------------------------------------------
module asbs_salt_lut (
	input  logic [7:0] index_byte,
	input  logic [3:0] offset,
	output logic [7:0] salt
);

	logic [3:0] lo;
	logic [3:0] hi;
	logic [3:0] len;
	logic [4:0] ring_sum;
	logic [4:0] ring_pos;
	logic [4:0] lo_pos;
	logic [3:0] hi_nib;

	assign lo  = index_byte[3:0];
	assign hi  = index_byte[7:4];
	assign len = asbs_pkg::pat_len(lo);

	// (start + offset) mod 15, sum stays below 30
	assign ring_sum = {1'b0, asbs_pkg::hi_start(hi)} + {1'b0, offset};
	assign ring_pos = (ring_sum >= asbs_pkg::RingLen) ? (ring_sum - asbs_pkg::RingLen) : ring_sum;

	// only meaningful while offset <= len, then it stays within 0..14
	assign lo_pos = asbs_pkg::NibLast + {1'b0, offset} - {1'b0, len};

	assign hi_nib = (hi == asbs_pkg::HiSpecial) ? asbs_pkg::HiSpecial
	                                            : asbs_pkg::hi_ring(ring_pos[3:0]);

	always_comb begin
		if (offset > len) begin
			salt = 8'h00;
		end else begin
			salt = {hi_nib, asbs_pkg::lo_seq(lo_pos[3:0])};
		end
	end

endmodule

[rtl/core/asbs_core.sv]
// ----------------------------------------------------------------------------
// asbs_core: scrambler state and word forming
// holds salt, index byte and offset; advances them once per item
// ----------------------------------------------------------------------------
module asbs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  asbs_pkg::item_t item,
	output logic [31:0]     word
);

	logic [7:0]  salt_q;
	logic [7:0]  index_q;
	logic [3:0]  offset_q;

	logic [7:0]  salt_cur;
	logic [7:0]  index_cur;
	logic [3:0]  offset_cur;
	logic [31:0] label_word;
	logic [7:0]  mid;
	logic [7:0]  index_nxt;
	logic [3:0]  offset_rl;
	logic [3:0]  offset_nxt;
	logic [7:0]  salt_nxt;

	// frame flag clears the state before this item
	assign salt_cur   = item.frame_start ? 8'h00 : salt_q;
	assign index_cur  = item.frame_start ? 8'h00 : index_q;
	assign offset_cur = item.frame_start ? 4'd0  : offset_q;

	assign label_word = {asbs_pkg::LabelByte, item.sample[31:8]};
	assign mid        = label_word[15:8];

	// nonzero middle byte reloads index and restarts offset
	assign index_nxt = (mid != 8'h00) ? (mid ^ salt_cur) : index_cur;
	assign offset_rl = (mid != 8'h00) ? 4'd0 : offset_cur;
	assign offset_nxt = (offset_rl < asbs_pkg::OffsetMax) ? (offset_rl + 4'd1) : offset_rl;

	assign word = {label_word[31:16], mid ^ salt_cur, label_word[7:0]};

	asbs_salt_lut u_salt_lut (
		.index_byte (index_nxt),
		.offset     (offset_nxt),
		.salt       (salt_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q   <= 8'h00;
			index_q  <= 8'h00;
			offset_q <= 4'd0;
		end else if (step) begin
			salt_q   <= salt_nxt;
			index_q  <= index_nxt;
			offset_q <= offset_nxt;
		end
	end

	// offset is never zero once an item has gone through
	a_offset_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (offset_q != 4'd0))
		else $error("offset zero after step");

	// state holds between items
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(salt_q) && $stable(index_q) && $stable(offset_q)))
		else $error("state changed without step");

	// frame start with a zero middle byte leaves index zero and no salt
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.frame_start && (item.sample[23:16] == 8'h00))
		|=> (index_q == 8'h00 && offset_q == 4'd1 && salt_q == 8'h00))
		else $error("frame start did not clear state");

	// a reload always restarts the offset at one
	a_reload_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (item.sample[23:16] != 8'h00)) |=> (offset_q == 4'd1))
		else $error("reload did not restart offset");

endmodule

[rtl/core/audio_sample_byte_scrambler.sv]
// ----------------------------------------------------------------------------
// audio_sample_byte_scrambler: pcm sample byte scrambler
// turns 32-bit pcm samples into labeled words with bits 15:8 scrambled
// ----------------------------------------------------------------------------
// Each accepted item is one channel's 32-bit sample, in frame order, with
// frame_start high on the first channel of a frame. The output word is
// 0x40 in the top byte, sample bits 31:8 below it, and bits 15:8 XORed with
// a salt carried from the previous channel. The block accepts one item per
// clock cycle while the sink takes words: an input register feeds combinational
// lookup and XOR logic whose state feedback closes within it, and a result
// register holds the word. Each accepted item passes the input register and
// then the result register before its word is shown.
// The ready path is combinational from word_ready through to sample_ready,
// so both registers keep moving whenever the sink takes.
// ----------------------------------------------------------------------------
module audio_sample_byte_scrambler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [31:0] sample_in,
	input  logic        frame_start,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] out_word
);

	// input register
	logic            valid_s1;
	asbs_pkg::item_t item_s1;

	// result register
	logic            valid_s2;
	logic [31:0]     word_s2;

	logic            advance;
	logic            step;
	logic [31:0]     word_nxt;

	// result register can load when empty or being drained
	assign advance      = !valid_s2 || word_ready;
	assign step         = valid_s1 && advance;
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1.sample      <= sample_in;
			item_s1.frame_start <= frame_start;
		end
	end

	// scrambler state advances exactly when an item moves to the result stage
	asbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.word   (word_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			word_s2 <= word_nxt;
		end
	end

	assign word_valid = valid_s2;
	assign out_word   = word_s2;

endmodule
